### hw/rtl/dmsp_pkg.sv
package dmsp_pkg;

	localparam int HeaderLen = 12;
	localparam int QDepth = 2;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [7:0] RootLabel = 8'h00;
	localparam logic [1:0] PtrMark = 2'b11;
	localparam logic [31:0] DotChar = 32'h0000_002e;

	typedef enum logic [3:0] {
		KIND_ID = 4'd0,
		KIND_FLAGS = 4'd1,
		KIND_QCOUNT = 4'd2,
		KIND_ACOUNT = 4'd3,
		KIND_CHAR = 4'd4,
		KIND_POINTER = 4'd5,
		KIND_TYPE = 4'd6,
		KIND_CLASS = 4'd7,
		KIND_TTL = 4'd8,
		KIND_RDATA = 4'd9,
		KIND_END = 4'd10,
		KIND_ERROR = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LEN = 3'd1,
		PH_LABEL = 3'd2,
		PH_PTR = 3'd3,
		PH_FIELDS = 3'd4,
		PH_RDATA = 3'd5,
		PH_DONE = 3'd6,
		PH_ERROR = 3'd7
	} phase_t;

	// class of a byte when read as a label length
	typedef enum logic [1:0] {
		CLS_LABEL = 2'd0,
		CLS_ROOT = 2'd1,
		CLS_PTR = 2'd2,
		CLS_RSVD = 2'd3
	} cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
		cls_t cls;
	} queue_item_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [31:0] value;
		logic in_answer;
		logic qr_bit;
		logic [3:0] op_code;
		logic authoritative;
		logic truncated;
		logic recursion_desired;
		logic recursion_available;
		logic [3:0] response_code;
		logic packet_end;
	} out_item_t;

endpackage

### hw/rtl/dmsp_front.sv
module dmsp_front (
	input logic byte_valid,
	output logic byte_ready,
	input dmsp_pkg::in_item_t byte_data,
	input logic queue_full,
	output logic push,
	output dmsp_pkg::queue_item_t push_item
);
	import dmsp_pkg::*;

	cls_t cls;

	// classify the byte as a would-be label length
	always_comb begin
		if (byte_data.data_byte == RootLabel) begin
			cls = CLS_ROOT;
		end else if (byte_data.data_byte[7:6] == PtrMark) begin
			cls = CLS_PTR;
		end else if (byte_data.data_byte[7:6] != 2'b00) begin
			cls = CLS_RSVD;
		end else begin
			cls = CLS_LABEL;
		end
	end

	assign byte_ready = !queue_full;
	assign push = byte_valid && !queue_full;
	assign push_item = '{data_byte: byte_data.data_byte, last_byte: byte_data.last_byte, cls: cls};

endmodule

### hw/rtl/dmsp_queue.sv
module dmsp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dmsp_pkg::queue_item_t push_item,
	input logic pop,
	output dmsp_pkg::queue_item_t head_item,
	output logic full,
	output logic empty
);
	import dmsp_pkg::*;

	queue_item_t entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full = (count_q == QCntW'(QDepth));
	assign empty = (count_q == '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

### hw/rtl/dmsp_back.sv
module dmsp_back (
	input logic clk,
	input logic arst_n,
	input dmsp_pkg::queue_item_t head_item,
	input logic queue_empty,
	output logic pop,
	output logic result_valid,
	input logic result_ready,
	output dmsp_pkg::out_item_t result_data
);
	import dmsp_pkg::*;

	phase_t phase_q, phase_nx;
	logic [3:0] pos_q, pos_nx;
	logic [15:0] q_left_q, q_left_nx;
	logic [15:0] a_left_q, a_left_nx;
	logic [5:0] label_left_q, label_left_nx;
	logic first_q, first_nx;
	logic [31:0] acc_q, acc_nx;
	logic [15:0] rdata_left_q, rdata_left_nx;
	logic sect_q, sect_nx;

	logic result_valid_q;
	out_item_t result_q;
	out_item_t res;
	logic has_res;

	logic [7:0] b;
	logic [15:0] w;

	assign b = head_item.data_byte;
	assign acc_nx = {acc_q[23:0], b};
	assign w = acc_nx[15:0];
	assign pop = !queue_empty && (!result_valid_q || result_ready);

	// next state
	always_comb begin
		logic rec_done;
		logic [5:0] lbl_dec;
		logic [15:0] rd_dec;
		logic [15:0] qd, ad;
		phase_nx = phase_q;
		pos_nx = pos_q;
		q_left_nx = q_left_q;
		a_left_nx = a_left_q;
		label_left_nx = label_left_q;
		first_nx = first_q;
		rdata_left_nx = rdata_left_q;
		sect_nx = sect_q;
		rec_done = 1'b0;
		qd = '0;
		ad = '0;
		lbl_dec = (label_left_q != '0) ? label_left_q - 1'b1 : label_left_q;
		rd_dec = (rdata_left_q != '0) ? rdata_left_q - 1'b1 : rdata_left_q;
		case (phase_q)
			PH_HEADER: begin
				if (pos_q == 4'd5) begin
					q_left_nx = w;
				end
				if (pos_q == 4'd7) begin
					a_left_nx = w;
				end
				if (pos_q >= 4'(HeaderLen - 1)) begin
					phase_nx = PH_DONE;
					rec_done = 1'b1;
				end else begin
					pos_nx = pos_q + 1'b1;
				end
			end
			PH_LEN: begin
				case (head_item.cls)
					CLS_ROOT: begin
						phase_nx = PH_FIELDS;
						pos_nx = '0;
					end
					CLS_PTR: phase_nx = PH_PTR;
					CLS_RSVD: phase_nx = PH_ERROR;
					default: begin
						label_left_nx = b[5:0];
						first_nx = 1'b0;
						phase_nx = PH_LABEL;
					end
				endcase
			end
			PH_LABEL: begin
				label_left_nx = lbl_dec;
				if (lbl_dec == '0) begin
					phase_nx = PH_LEN;
				end
			end
			PH_PTR: begin
				phase_nx = PH_FIELDS;
				pos_nx = '0;
			end
			PH_FIELDS: begin
				if (pos_q == 4'd3 && !sect_q) begin
					rec_done = 1'b1;
				end else if (pos_q >= 4'd9) begin
					rdata_left_nx = w;
					if (w == '0) begin
						rec_done = 1'b1;
					end else begin
						phase_nx = PH_RDATA;
					end
				end else begin
					pos_nx = pos_q + 1'b1;
				end
			end
			PH_RDATA: begin
				rdata_left_nx = rd_dec;
				if (rd_dec == '0) begin
					rec_done = 1'b1;
				end
			end
			default: ;
		endcase
		// end of a record, or of the header: pick what comes next
		if (rec_done) begin
			qd = q_left_nx;
			ad = a_left_nx;
			if (phase_q != PH_HEADER) begin
				if (!sect_q && qd != '0) begin
					qd = qd - 1'b1;
				end
				if (sect_q && ad != '0) begin
					ad = ad - 1'b1;
				end
			end
			q_left_nx = qd;
			a_left_nx = ad;
			if (qd != '0 || ad != '0) begin
				sect_nx = (qd == '0);
				phase_nx = PH_LEN;
				first_nx = 1'b1;
				label_left_nx = '0;
				pos_nx = '0;
			end else begin
				phase_nx = PH_DONE;
			end
		end
	end

	// result of the byte
	always_comb begin
		res = '0;
		has_res = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				case (pos_q)
					4'd1: begin
						res.kind = KIND_ID;
						res.value = {16'b0, w};
						has_res = 1'b1;
					end
					4'd3: begin
						res.kind = KIND_FLAGS;
						res.value = {16'b0, w};
						res.qr_bit = w[15];
						res.op_code = w[14:11];
						res.authoritative = w[10];
						res.truncated = w[9];
						res.recursion_desired = w[8];
						res.recursion_available = w[7];
						res.response_code = w[3:0];
						has_res = 1'b1;
					end
					4'd5: begin
						res.kind = KIND_QCOUNT;
						res.value = {16'b0, w};
						has_res = 1'b1;
					end
					4'd7: begin
						res.kind = KIND_ACOUNT;
						res.value = {16'b0, w};
						has_res = 1'b1;
					end
					default: ;
				endcase
			end
			PH_LEN: begin
				if (head_item.cls == CLS_RSVD) begin
					res.kind = KIND_ERROR;
					has_res = 1'b1;
				end else if (head_item.cls == CLS_LABEL && !first_q) begin
					res.kind = KIND_CHAR;
					res.value = DotChar;
					res.in_answer = sect_q;
					has_res = 1'b1;
				end
			end
			PH_LABEL: begin
				res.kind = KIND_CHAR;
				res.value = {24'b0, b};
				res.in_answer = sect_q;
				has_res = 1'b1;
			end
			PH_PTR: begin
				res.kind = KIND_POINTER;
				res.value = {18'b0, w[13:0]};
				res.in_answer = sect_q;
				has_res = 1'b1;
			end
			PH_FIELDS: begin
				res.in_answer = sect_q;
				if (pos_q == 4'd1) begin
					res.kind = KIND_TYPE;
					res.value = {16'b0, w};
					has_res = 1'b1;
				end else if (pos_q == 4'd3) begin
					res.kind = KIND_CLASS;
					res.value = {16'b0, w};
					has_res = 1'b1;
				end else if (pos_q == 4'd7) begin
					res.kind = KIND_TTL;
					res.value = acc_nx;
					has_res = 1'b1;
				end else begin
					res.in_answer = 1'b0;
				end
			end
			PH_RDATA: begin
				res.kind = KIND_RDATA;
				res.value = {24'b0, b};
				res.in_answer = sect_q;
				has_res = 1'b1;
			end
			default: ;
		endcase
		if (head_item.last_byte) begin
			if (phase_nx == PH_HEADER) begin
				res = '0;
				res.kind = KIND_ERROR;
				has_res = 1'b1;
			end else if (!has_res) begin
				res = '0;
				res.kind = KIND_END;
				has_res = 1'b1;
			end
			res.packet_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			q_left_q <= '0;
			a_left_q <= '0;
			label_left_q <= '0;
			first_q <= 1'b1;
			acc_q <= '0;
			rdata_left_q <= '0;
			sect_q <= 1'b0;
		end else if (pop) begin
			if (head_item.last_byte) begin
				phase_q <= PH_HEADER;
				pos_q <= '0;
				q_left_q <= '0;
				a_left_q <= '0;
				label_left_q <= '0;
				first_q <= 1'b1;
				acc_q <= '0;
				rdata_left_q <= '0;
				sect_q <= 1'b0;
			end else begin
				phase_q <= phase_nx;
				pos_q <= pos_nx;
				q_left_q <= q_left_nx;
				a_left_q <= a_left_nx;
				label_left_q <= label_left_nx;
				first_q <= first_nx;
				acc_q <= acc_nx;
				rdata_left_q <= rdata_left_nx;
				sect_q <= sect_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop && has_res) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_item.last_byte |=> phase_q == PH_HEADER && pos_q == '0)
		else $error("last byte did not return parser to header");
	a_label_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LABEL |-> label_left_q != '0)
		else $error("label phase with no bytes left");
	a_rdata_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RDATA |-> rdata_left_q != '0)
		else $error("rdata phase with no bytes left");

endmodule

### hw/rtl/dns_message_stream_parser_core.sv
// dns message stream parser
//
// byte channel: byte_valid / byte_ready / byte_data carries one message byte per
// beat, with last_byte set on the final byte of a message
// result channel: result_valid / result_ready / result_data carries one parsed
// field per beat (header id, flags, counts, name chars, pointers, type, class,
// ttl, rdata, end or error); a byte yields zero or one result
// data path: a byte accepted goes through the two-entry queue, and its result
// is registered in the output register when the parser takes it from the queue
// throughput: one byte per cycle sustained while result_ready is high; the
// parser state machine updates once per byte and is the only loop
// reset: arst_n clears the queue, the output register and the parser, which
// then waits for a header
// stall: when result_ready is low the output register holds its beat and the
// parser stops taking bytes, whether or not they give a result; the queue
// then fills (two entries) and byte_ready drops
module dns_message_stream_parser_core (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_ready,
	input dmsp_pkg::in_item_t byte_data,
	output logic result_valid,
	input logic result_ready,
	output dmsp_pkg::out_item_t result_data
);
	import dmsp_pkg::*;

	queue_item_t push_item;
	queue_item_t head_item;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// front: handshake and label-length classification
	dmsp_front u_front (
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data (byte_data),
		.queue_full (q_full),
		.push (q_push),
		.push_item (push_item)
	);

	// decoupling queue between classification and parsing
	dmsp_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (q_push),
		.push_item (push_item),
		.pop (q_pop),
		.head_item (head_item),
		.full (q_full),
		.empty (q_empty)
	);

	// back: parser state machine and output register
	dmsp_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head_item (head_item),
		.queue_empty (q_empty),
		.pop (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data (result_data)
	);

endmodule

### bench/dns_message_stream_parser_core_tb.sv
module dns_message_stream_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dmsp_pkg::*;

	// stop adding random messages once this many bytes have been accepted
	localparam int ByteTarget = 900;
	// one long receiver hold-off, taken once this many results have been taken
	localparam int HoldAfter = 100;
	localparam int HoldCycles = 300;
	// drain cycles after the last expected result, to catch strays
	localparam int TailCycles = 20;
	// mismatch lines printed before going quiet (all are still counted)
	localparam int PrintCap = 40;

	// tracks the parser state per accepted byte and holds the parsed fields
	// still owed by the block, oldest first
	class dns_field_tracker;
		phase_t phase;
		logic [3:0] pos;
		logic [15:0] q_left;
		logic [15:0] a_left;
		logic [5:0] label_left;
		logic first_label;
		logic [31:0] acc;
		logic [15:0] rd_left;
		logic sect;

		out_item_t pending_fields[$];
		int mismatches;
		int taken;

		function new();
			mismatches = 0;
			taken = 0;
			clear_state();
		endfunction

		function void clear_state();
			phase = PH_HEADER;
			pos = '0;
			q_left = '0;
			a_left = '0;
			label_left = '0;
			first_label = 1'b1;
			acc = '0;
			rd_left = '0;
			sect = 1'b0;
		endfunction

		function void start_name(logic s);
			sect = s;
			phase = PH_LEN;
			first_label = 1'b1;
			label_left = '0;
			pos = '0;
		endfunction

		function void next_record();
			if (q_left != 0) start_name(1'b0);
			else if (a_left != 0) start_name(1'b1);
			else phase = PH_DONE;
		endfunction

		function void record_done();
			if (sect == 1'b0) begin
				if (q_left != 0) q_left--;
			end else begin
				if (a_left != 0) a_left--;
			end
			next_record();
		endfunction

		// advance the parse by one byte; returns 1 when the byte yields a field
		function bit parse_byte(in_item_t it, output out_item_t r);
			logic [7:0] b;
			logic [15:0] w;
			bit hit;
			r = '0;
			hit = 1'b0;
			b = it.data_byte;
			acc = {acc[23:0], b};
			w = acc[15:0];
			case (phase)
				PH_HEADER: begin
					case (pos)
						4'd1: begin
							r.kind = KIND_ID;
							r.value = {16'h0, w};
							hit = 1'b1;
						end
						4'd3: begin
							r.kind = KIND_FLAGS;
							r.value = {16'h0, w};
							r.qr_bit = w[15];
							r.op_code = w[14:11];
							r.authoritative = w[10];
							r.truncated = w[9];
							r.recursion_desired = w[8];
							r.recursion_available = w[7];
							r.response_code = w[3:0];
							hit = 1'b1;
						end
						4'd5: begin
							q_left = w;
							r.kind = KIND_QCOUNT;
							r.value = {16'h0, w};
							hit = 1'b1;
						end
						4'd7: begin
							a_left = w;
							r.kind = KIND_ACOUNT;
							r.value = {16'h0, w};
							hit = 1'b1;
						end
						default: ;
					endcase
					if (pos >= HeaderLen - 1) next_record();
					else pos++;
				end
				PH_LEN: begin
					if (b == RootLabel) begin
						phase = PH_FIELDS;
						pos = '0;
					end else if (b[7:6] == PtrMark) begin
						phase = PH_PTR;
					end else if (b[7:6] != 2'b00) begin
						r.kind = KIND_ERROR;
						hit = 1'b1;
						phase = PH_ERROR;
					end else begin
						label_left = b[5:0];
						if (!first_label) begin
							r.kind = KIND_CHAR;
							r.value = DotChar;
							r.in_answer = sect;
							hit = 1'b1;
						end
						first_label = 1'b0;
						phase = PH_LABEL;
					end
				end
				PH_LABEL: begin
					r.kind = KIND_CHAR;
					r.value = {24'h0, b};
					r.in_answer = sect;
					hit = 1'b1;
					if (label_left > 0) label_left--;
					if (label_left == 0) phase = PH_LEN;
				end
				PH_PTR: begin
					r.kind = KIND_POINTER;
					r.value = {18'h0, w[13:0]};
					r.in_answer = sect;
					hit = 1'b1;
					phase = PH_FIELDS;
					pos = '0;
				end
				PH_FIELDS: begin
					if (pos == 4'd1) begin
						r.kind = KIND_TYPE;
						r.value = {16'h0, w};
						r.in_answer = sect;
						hit = 1'b1;
					end else if (pos == 4'd3) begin
						r.kind = KIND_CLASS;
						r.value = {16'h0, w};
						r.in_answer = sect;
						hit = 1'b1;
					end else if (pos == 4'd7) begin
						r.kind = KIND_TTL;
						r.value = acc;
						r.in_answer = sect;
						hit = 1'b1;
					end
					if (pos == 4'd3 && sect == 1'b0) begin
						record_done();
					end else if (pos >= 4'd9) begin
						rd_left = w;
						if (rd_left == 0) record_done();
						else phase = PH_RDATA;
					end else begin
						pos++;
					end
				end
				PH_RDATA: begin
					r.kind = KIND_RDATA;
					r.value = {24'h0, b};
					r.in_answer = sect;
					hit = 1'b1;
					if (rd_left > 0) rd_left--;
					if (rd_left == 0) record_done();
				end
				default: ;
			endcase
			if (it.last_byte) begin
				if (phase == PH_HEADER) begin
					r = '0;
					r.kind = KIND_ERROR;
				end else if (!hit) begin
					r = '0;
					r.kind = KIND_END;
				end
				r.packet_end = 1'b1;
				hit = 1'b1;
				clear_state();
			end
			return hit;
		endfunction

		function bit note_byte(in_item_t it);
			out_item_t r;
			bit hit;
			hit = parse_byte(it, r);
			if (hit) pending_fields.push_back(r);
			return hit;
		endfunction

		function int pending();
			return pending_fields.size();
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PrintCap) $display("mismatch: result %0d: %s", taken, msg);
			mismatches++;
		endtask

		task cmp(string name, logic [31:0] g, logic [31:0] w);
			if (g !== w) report_mismatch($sformatf("%s got %h want %h", name, g, w));
		endtask

		task check_field(out_item_t got);
			out_item_t want;
			if (pending_fields.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d value %h",
					got.kind, got.value));
				taken++;
				return;
			end
			want = pending_fields.pop_front();
			cmp("kind", 32'(got.kind), 32'(want.kind));
			cmp("value", got.value, want.value);
			cmp("in_answer", 32'(got.in_answer), 32'(want.in_answer));
			cmp("qr_bit", 32'(got.qr_bit), 32'(want.qr_bit));
			cmp("op_code", 32'(got.op_code), 32'(want.op_code));
			cmp("authoritative", 32'(got.authoritative), 32'(want.authoritative));
			cmp("truncated", 32'(got.truncated), 32'(want.truncated));
			cmp("recursion_desired", 32'(got.recursion_desired),
				32'(want.recursion_desired));
			cmp("recursion_available", 32'(got.recursion_available),
				32'(want.recursion_available));
			cmp("response_code", 32'(got.response_code), 32'(want.response_code));
			cmp("packet_end", 32'(got.packet_end), 32'(want.packet_end));
			taken++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic byte_valid;
	logic byte_ready;
	in_item_t byte_data;
	logic result_valid;
	logic result_ready;
	out_item_t result_data;

	dns_field_tracker tracker = new();

	// message under construction, sent front to back
	logic [7:0] msg_q[$];
	// sender burst bookkeeping and count of bytes accepted
	int burst_left = 0;
	int sent = 0;

	dns_message_stream_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data)
	);

	always #10 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#5ms;
		$display("dns_message_stream_parser_core verification failed");
		$finish;
	end

	// offer one beat; bursts of random length separated by random gaps,
	// gaps land anywhere inside a message so every parse phase sees them
	task automatic send_byte(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_data <= it;
		// the beat goes at the first edge that sees ready high
		do @(posedge clk); while (!byte_ready);
		void'(tracker.note_byte(it));
		sent++;
	endtask

	// push the whole of msg_q, marking its final byte
	task automatic send_message();
		in_item_t it;
		for (int i = 0; i < msg_q.size(); i++) begin
			it.data_byte = msg_q[i];
			it.last_byte = (i == msg_q.size() - 1);
			send_byte(it);
		end
	endtask

	// sender goes quiet until every owed field has come back
	task automatic drain();
		byte_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	function automatic void add16(logic [15:0] v);
		msg_q.push_back(v[15:8]);
		msg_q.push_back(v[7:0]);
	endfunction

	// a name: a few labels, then root, a compression pointer or, rarely,
	// a reserved prefix that sends the parser into its error state
	function automatic void add_name();
		int labels;
		int len;
		int pick;
		labels = $urandom_range(0, 3);
		for (int l = 0; l < labels; l++) begin
			len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 6);
			msg_q.push_back(8'(len));
			for (int c = 0; c < len; c++) msg_q.push_back(8'($urandom));
		end
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			msg_q.push_back(RootLabel);
		end else if (pick < 9) begin
			msg_q.push_back({PtrMark, 6'($urandom)});
			msg_q.push_back(8'($urandom));
		end else begin
			msg_q.push_back({($urandom_range(0, 1) ? 2'b01 : 2'b10), 6'($urandom)});
		end
	endfunction

	// mostly well-formed messages with random content; the rest is cut short
	// inside or after the header, or plain noise
	function automatic void build_message();
		logic [15:0] qd;
		logic [15:0] an;
		logic [15:0] rdlen;
		int style;
		int cut;
		msg_q.delete();
		qd = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		an = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		add16(16'($urandom));
		add16(16'($urandom));
		add16(qd);
		add16(an);
		add16(16'($urandom));
		add16(16'($urandom));
		for (int q = 0; q < qd && q < 4; q++) begin
			add_name();
			add16(16'($urandom));
			add16(16'($urandom));
		end
		for (int a = 0; a < an && a < 4; a++) begin
			add_name();
			add16(16'($urandom));
			add16(16'($urandom));
			add16(16'($urandom));
			add16(16'($urandom));
			case ($urandom_range(0, 19))
				0, 1, 2, 3: rdlen = 16'h0;
				4: rdlen = 16'($urandom);
				default: rdlen = 16'($urandom_range(1, 6));
			endcase
			add16(rdlen);
			for (int d = 0; d < rdlen && d < 8; d++) msg_q.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
		style = $urandom_range(0, 9);
		if (style == 0) begin
			cut = $urandom_range(1, HeaderLen);
			while (msg_q.size() > cut) void'(msg_q.pop_back());
		end else if (style == 1) begin
			cut = $urandom_range(1, msg_q.size());
			while (msg_q.size() > cut) void'(msg_q.pop_back());
		end else if (style == 2) begin
			msg_q.delete();
			repeat ($urandom_range(1, 30)) msg_q.push_back(8'($urandom));
		end
	endfunction

	// receiver: checks each beat taken, then picks ready for the next edge
	// from one of four random patterns; one long hold-off lets
	// the block fill up and push back on the byte side
	initial begin
		int cyc;
		int rx_mode;
		bit held;
		cyc = 0;
		rx_mode = 0;
		held = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) tracker.check_field(result_data);
			if (!held && tracker.taken >= HoldAfter) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			cyc++;
			if (cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 3) == 0);
				default: result_ready <= (cyc % 3 == 0);
			endcase
		end
	end

	initial begin
		int msg_count;
		byte_valid <= 1'b0;
		byte_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte message: last byte inside the header
		msg_q = '{8'h00};
		send_message();
		// header cut at the flags word: id, then error in place of flags
		msg_q = '{8'hff, 8'hff, 8'hff, 8'hff};
		send_message();
		// one question whose name is only a pointer with all offset bits set,
		// every flag bit set, zero answers
		msg_q = '{8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h01, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h01, 8'h00, 8'h01};
		send_message();
		drain();

		msg_count = 0;
		while (sent < ByteTarget) begin
			build_message();
			send_message();
			msg_count++;
			if (msg_count % 25 == 0) drain();
		end
		drain();
		repeat (TailCycles) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("dns_message_stream_parser_core verification clean");
		end else begin
			$display("dns_message_stream_parser_core verification failed");
		end
		$finish;
	end

endmodule
